>>> sv/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg: shared types and constants for the go-to-point controller
// Register indexes, reset values, the cordic angle table and the records
// passed between the pipeline blocks.
// ----------------------------------------------------------------------------
package gtp_pkg;

   // number of cells in the chain: one root bit and one rotation per cell
   localparam int CORDIC_STEPS = 16;

   // quarter turn in units of 2^-16 rad
   localparam logic signed [19:0] QUARTER_TURN = 20'sd102944;

   // configuration register indexes
   localparam logic [7:0] REG_MAX_FORWARD_SPEED = 8'd0;
   localparam logic [7:0] REG_MAX_TURN_RATE     = 8'd1;
   localparam logic [7:0] REG_LINEAR_GAIN       = 8'd2;
   localparam logic [7:0] REG_ANGULAR_GAIN      = 8'd3;
   localparam logic [7:0] REG_TURN_ONLY_ANGLE   = 8'd4;

   // register reset values
   localparam logic [14:0] RST_MAX_FORWARD_SPEED = 15'd1000;
   localparam logic [14:0] RST_MAX_TURN_RATE     = 15'd4096;
   localparam logic [15:0] RST_LINEAR_GAIN       = 16'd128;
   localparam logic [15:0] RST_ANGULAR_GAIN      = 16'd384;
   localparam logic [13:0] RST_TURN_ONLY_ANGLE   = 14'd1638;

   // controller settings as seen by the output stages
   typedef struct packed {
      logic [14:0] max_forward_speed;
      logic [14:0] max_turn_rate;
      logic [15:0] linear_gain;
      logic [15:0] angular_gain;
      logic [13:0] turn_only_angle;
   } cfg_type;

   // work record handed from cell to cell
   typedef struct packed {
      logic [31:0]        rem;    // square root remainder
      logic [31:0]        root;   // partial square root
      logic signed [34:0] u;      // cordic x, scaled by 2^16
      logic signed [34:0] v;      // cordic y, scaled by 2^16
      logic signed [19:0] z;      // accumulated angle, 2^-16 rad
      logic               zero;   // target at the origin
   } cell_data_type;

   // atan(2^-i) in units of 2^-16 rad, rounded
   function automatic logic signed [19:0] atan_step(input int idx);
      logic signed [19:0] r;
      case (idx)
         0:       r = 20'sd51472;
         1:       r = 20'sd30386;
         2:       r = 20'sd16055;
         3:       r = 20'sd8150;
         4:       r = 20'sd4091;
         5:       r = 20'sd2047;
         6:       r = 20'sd1024;
         7:       r = 20'sd512;
         8:       r = 20'sd256;
         9:       r = 20'sd128;
         10:      r = 20'sd64;
         11:      r = 20'sd32;
         12:      r = 20'sd16;
         13:      r = 20'sd8;
         14:      r = 20'sd4;
         15:      r = 20'sd2;
         default: r = 20'sd0;
      endcase
      return r;
   endfunction

endpackage

>>> sv/go_to_point_velocity_controller_top.sv
// ----------------------------------------------------------------------------
// go_to_point_velocity_controller_top: proportional go-to-goal controller
// Turns a target point in robot-local millimetres into a capped forward
// speed and a clamped turn rate through a chain of root/cordic cells.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  target_x, target_y
//   rsp      out        rsp_tvalid/rsp_tready  forward_speed, turn_rate
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One point enters per cycle while the output is not held back. Stages:
// 2 input stages, one cell per cordic step and root bit (16), 3 output stages.
// Every stage has its own valid, so bubbles close up while a result waits.
// Reset clears all valids and loads the register defaults; csr_ready is
// always high; the output stages read the registers live, so a write also affects points in flight.
// ----------------------------------------------------------------------------
module go_to_point_velocity_controller_top (
   input  logic        clock,
   input  logic        reset,
   // input points
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] target_x, [31:16] target_y
   // velocity commands
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [14:0] forward_speed, [30:15] turn_rate
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int N = gtp_pkg::CORDIC_STEPS;

   // configuration registers
   logic [14:0] max_fwd_ff, max_fwd_in;
   logic [14:0] max_turn_ff, max_turn_in;
   logic [15:0] lin_gain_ff, lin_gain_in;
   logic [15:0] ang_gain_ff, ang_gain_in;
   logic [13:0] turn_only_ff, turn_only_in;
   gtp_pkg::cfg_type cfg;

   // chain links: link 0 from the front, link N into the back
   logic                   link_valid [N+1];
   logic                   link_ready [N+1];
   gtp_pkg::cell_data_type link_data  [N+1];

   logic [14:0]        fwd_speed;
   logic signed [15:0] turn_rate;

   // register write decode
   assign csr_ready = 1'b1;

   always_comb begin
      max_fwd_in   = max_fwd_ff;
      max_turn_in  = max_turn_ff;
      lin_gain_in  = lin_gain_ff;
      ang_gain_in  = ang_gain_ff;
      turn_only_in = turn_only_ff;
      if (csr_valid) begin
         case (csr_index)
            gtp_pkg::REG_MAX_FORWARD_SPEED: max_fwd_in   = csr_data[14:0];
            gtp_pkg::REG_MAX_TURN_RATE:     max_turn_in  = csr_data[14:0];
            gtp_pkg::REG_LINEAR_GAIN:       lin_gain_in  = csr_data;
            gtp_pkg::REG_ANGULAR_GAIN:      ang_gain_in  = csr_data;
            gtp_pkg::REG_TURN_ONLY_ANGLE:   turn_only_in = csr_data[13:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_fwd_ff   <= gtp_pkg::RST_MAX_FORWARD_SPEED;
         max_turn_ff  <= gtp_pkg::RST_MAX_TURN_RATE;
         lin_gain_ff  <= gtp_pkg::RST_LINEAR_GAIN;
         ang_gain_ff  <= gtp_pkg::RST_ANGULAR_GAIN;
         turn_only_ff <= gtp_pkg::RST_TURN_ONLY_ANGLE;
      end else begin
         max_fwd_ff   <= max_fwd_in;
         max_turn_ff  <= max_turn_in;
         lin_gain_ff  <= lin_gain_in;
         ang_gain_ff  <= ang_gain_in;
         turn_only_ff <= turn_only_in;
      end
   end

   always_comb begin
      cfg.max_forward_speed = max_fwd_ff;
      cfg.max_turn_rate     = max_turn_ff;
      cfg.linear_gain       = lin_gain_ff;
      cfg.angular_gain      = ang_gain_ff;
      cfg.turn_only_angle   = turn_only_ff;
   end

   // input stages
   gtp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .target_x  (req_tdata[15:0]),
      .target_y  (req_tdata[31:16]),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // cell chain
   for (genvar i = 0; i < N; i++) begin : g_cell
      gtp_cell #(
         .STEP (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   // output stages
   gtp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (link_valid[N]),
      .in_ready      (link_ready[N]),
      .in_data       (link_data[N]),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .forward_speed (fwd_speed),
      .turn_rate     (turn_rate)
   );

   assign rsp_tdata = {1'b0, turn_rate, fwd_speed};

`ifndef SYNTHESIS
   // forward speed never exceeds its cap
   a_fwd_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fwd_speed <= max_fwd_ff))
      else $error("forward speed above cap");

   // turn rate stays inside the symmetric clamp
   a_turn_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (($signed({turn_rate[15], turn_rate}) <= $signed({2'b0, max_turn_ff}))
                   && ($signed({turn_rate[15], turn_rate}) >= -$signed({2'b0, max_turn_ff}))))
      else $error("turn rate outside clamp");

   // input stalls only while a result is held back
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled with output free");

   // registers come out of reset at their defaults
   a_reset_cfg: assert property (@(posedge clock)
      $past(reset) |-> (max_fwd_ff == gtp_pkg::RST_MAX_FORWARD_SPEED
                     && turn_only_ff == gtp_pkg::RST_TURN_ONLY_ANGLE))
      else $error("register defaults not loaded");
`endif

endmodule

>>> sv/gtp_front.sv
// ----------------------------------------------------------------------------
// gtp_front: input stages of the controller
// Squares the coordinates, moves the vector into the right half plane and
// builds the first work record for the cell chain. Two register stages.
// ----------------------------------------------------------------------------
module gtp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [15:0]     target_x,
   input  logic signed [15:0]     target_y,
   output logic                   out_valid,
   input  logic                   out_ready,
   output gtp_pkg::cell_data_type out_data
);

   // stage a registers
   logic               a_valid_ff, a_valid_in;
   logic [31:0]        a_sq_x_ff, a_sq_x_in;
   logic [31:0]        a_sq_y_ff, a_sq_y_in;
   logic signed [34:0] a_u_ff, a_u_in;
   logic signed [34:0] a_v_ff, a_v_in;
   logic signed [19:0] a_z_ff, a_z_in;
   logic               a_zero_ff, a_zero_in;
   logic               a_ready;

   // stage b registers
   logic                   b_valid_ff, b_valid_in;
   gtp_pkg::cell_data_type b_data_ff, b_data_in;

   logic signed [31:0] prod_x, prod_y;
   logic signed [16:0] x_ext, y_ext, u_rot, v_rot;

   // squares and quarter turn pre-rotation
   always_comb begin
      prod_x = target_x * target_x;
      prod_y = target_y * target_y;
      x_ext  = {target_x[15], target_x};
      y_ext  = {target_y[15], target_y};
      if (target_y < 0) begin
         if (target_x >= 0) begin
            u_rot  = x_ext;
            v_rot  = -y_ext;
            a_z_in = gtp_pkg::QUARTER_TURN;
         end else begin
            u_rot  = -x_ext;
            v_rot  = y_ext;
            a_z_in = -gtp_pkg::QUARTER_TURN;
         end
      end else begin
         u_rot  = y_ext;
         v_rot  = x_ext;
         a_z_in = 20'sd0;
      end
      a_sq_x_in  = unsigned'(prod_x);
      a_sq_y_in  = unsigned'(prod_y);
      a_u_in     = {{2{u_rot[16]}}, u_rot, 16'b0};
      a_v_in     = {{2{v_rot[16]}}, v_rot, 16'b0};
      a_zero_in  = (target_x == 16'sd0) && (target_y == 16'sd0);
      a_valid_in = in_valid;
   end

   // stage a handshake
   assign a_ready  = !b_valid_ff || out_ready;
   assign in_ready = !a_valid_ff || a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (in_ready) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         a_sq_x_ff <= a_sq_x_in;
         a_sq_y_ff <= a_sq_y_in;
         a_u_ff    <= a_u_in;
         a_v_ff    <= a_v_in;
         a_z_ff    <= a_z_in;
         a_zero_ff <= a_zero_in;
      end
   end

   // sum of squares and first work record
   always_comb begin
      b_data_in.rem  = a_sq_x_ff + a_sq_y_ff;
      b_data_in.root = 32'd0;
      b_data_in.u    = a_u_ff;
      b_data_in.v    = a_v_ff;
      b_data_in.z    = a_z_ff;
      b_data_in.zero = a_zero_ff;
      b_valid_in     = a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_ready) begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

>>> sv/gtp_cell.sv
// ----------------------------------------------------------------------------
// gtp_cell: one cell of the chain
// Works out one bit of the integer square root and one cordic vectoring
// rotation, then hands the record to the next cell.
// ----------------------------------------------------------------------------
module gtp_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  gtp_pkg::cell_data_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output gtp_pkg::cell_data_type out_data
);

   localparam logic [31:0]        SQ_BIT = 32'd1 << (30 - 2 * STEP);
   localparam logic signed [19:0] ATAN   = gtp_pkg::atan_step(STEP);

   logic                   valid_ff, valid_in;
   gtp_pkg::cell_data_type data_ff, data_in;

   logic [31:0]        trial;
   logic signed [34:0] u_cur, v_cur, du, dv;

   // one root bit and one rotation
   always_comb begin
      data_in = in_data;
      trial   = in_data.root + SQ_BIT;
      if (in_data.rem >= trial) begin
         data_in.rem  = in_data.rem - trial;
         data_in.root = (in_data.root >> 1) + SQ_BIT;
      end else begin
         data_in.root = in_data.root >> 1;
      end
      u_cur = $signed(in_data.u);
      v_cur = $signed(in_data.v);
      du    = v_cur >>> STEP;
      dv    = u_cur >>> STEP;
      if (v_cur >= 0) begin
         data_in.u = u_cur + du;
         data_in.v = v_cur - dv;
         data_in.z = $signed(in_data.z) + ATAN;
      end else begin
         data_in.u = u_cur - du;
         data_in.v = v_cur + dv;
         data_in.z = $signed(in_data.z) - ATAN;
      end
      valid_in = in_valid;
   end

   // cell handshake
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> sv/gtp_back.sv
// ----------------------------------------------------------------------------
// gtp_back: output stages of the controller
// Rounds the bearing, applies the gains, caps speed and turn rate and holds
// the result until it is taken. Three register stages.
// ----------------------------------------------------------------------------
module gtp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  gtp_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  gtp_pkg::cell_data_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [14:0]            forward_speed,
   output logic signed [15:0]     turn_rate
);

   // stage a: distance and bearing
   logic               a_valid_ff, a_valid_in, a_ready;
   logic [15:0]        a_dist_ff, a_dist_in;
   logic [14:0]        a_mag_ff, a_mag_in;
   logic               a_neg_ff, a_neg_in;

   // stage b: scaled products
   logic               b_valid_ff, b_valid_in, b_ready;
   logic [23:0]        b_fwd_ff, b_fwd_in;
   logic [22:0]        b_rot_ff, b_rot_in;
   logic               b_neg_ff, b_neg_in;
   logic               b_over_ff, b_over_in;

   // stage c: result register
   logic               c_valid_ff, c_valid_in;
   logic [14:0]        c_fwd_ff, c_fwd_in;
   logic signed [15:0] c_rot_ff, c_rot_in;

   logic signed [19:0] z_round;
   logic signed [15:0] angle;
   logic [31:0]        fwd_prod;
   logic [30:0]        rot_prod;
   logic [14:0]        rot_mag;

   // round the angle to 1/4096 rad, origin gives zero
   always_comb begin
      z_round    = $signed(in_data.z) + 20'sd8;
      angle      = in_data.zero ? 16'sd0 : 16'(z_round >>> 4);
      a_neg_in   = angle < 0;
      a_mag_in   = a_neg_in ? 15'(-angle) : 15'(angle);
      a_dist_in  = in_data.root[15:0];
      a_valid_in = in_valid;
   end

   assign a_ready  = !b_valid_ff || b_ready;
   assign in_ready = !a_valid_ff || a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (in_ready) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         a_dist_ff <= a_dist_in;
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
      end
   end

   // gain products, truncated by 256
   always_comb begin
      fwd_prod   = cfg.linear_gain * a_dist_ff;
      rot_prod   = cfg.angular_gain * a_mag_ff;
      b_fwd_in   = fwd_prod[31:8];
      b_rot_in   = rot_prod[30:8];
      b_neg_in   = a_neg_ff;
      b_over_in  = {1'b0, a_mag_ff} > {2'b0, cfg.turn_only_angle} ? 1'b1 : 1'b0;
      b_valid_in = a_valid_ff;
   end

   assign b_ready = !c_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_ready) begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && a_valid_ff) begin
         b_fwd_ff  <= b_fwd_in;
         b_rot_ff  <= b_rot_in;
         b_neg_ff  <= b_neg_in;
         b_over_ff <= b_over_in;
      end
   end

   // caps, turn-only cutoff and sign
   always_comb begin
      if (b_over_ff) begin
         c_fwd_in = 15'd0;
      end else if (b_fwd_ff > {9'b0, cfg.max_forward_speed}) begin
         c_fwd_in = cfg.max_forward_speed;
      end else begin
         c_fwd_in = b_fwd_ff[14:0];
      end
      if (b_rot_ff > {8'b0, cfg.max_turn_rate}) begin
         rot_mag = cfg.max_turn_rate;
      end else begin
         rot_mag = b_rot_ff[14:0];
      end
      c_rot_in   = b_neg_ff ? -$signed({1'b0, rot_mag}) : $signed({1'b0, rot_mag});
      c_valid_in = b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (b_ready) begin
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && b_valid_ff) begin
         c_fwd_ff <= c_fwd_in;
         c_rot_ff <= c_rot_in;
      end
   end

   assign out_valid     = c_valid_ff;
   assign forward_speed = c_fwd_ff;
   assign turn_rate     = c_rot_ff;

endmodule

>>> tb/tb_go_to_point_velocity_controller_top.sv
// ----------------------------------------------------------------------------
// tb_go_to_point_velocity_controller_top: testbench for the go-to-point
// velocity controller
// Sends target points on the request stream and predicts each velocity
// command with an integer square root and a bit-exact cordic bearing. Every
// command is checked in order against that prediction. Runs directed corner
// points, register extremes and write masking, then random traffic under
// several register settings and idle patterns on both streams.
// ----------------------------------------------------------------------------
module tb_go_to_point_velocity_controller_top;

   localparam int CLOCK_HALF     = 4;
   localparam int RESET_CYCLES   = 10;
   localparam int PIPE_LATENCY   = 21;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_POINTS  = 1248;

   // writes to these indexes must leave every register untouched
   localparam logic [7:0] REG_UNUSED_FIRST = 8'd5;
   localparam logic [7:0] REG_UNUSED_LAST  = 8'hFF;

   // one velocity command as the block reports it
   typedef struct {
      logic [14:0]        speed;
      logic signed [15:0] turn;
   } velocity_cmd_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;

   gtp_pkg::cfg_type shadow_cfg;
   velocity_cmd_type pending_cmds[$];
   int               error_count   = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               quiet_cycles  = 0;
   int               atan_lut[16]  = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};

   go_to_point_velocity_controller_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock
   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // floor of the square root, bit by bit
   function automatic longint int_sqrt(input longint n);
      longint root;
      longint probe;
      root  = 0;
      probe = longint'(1) << 32;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n    = n - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // atan2(x, y) in 1/4096 rad via 16 cordic vectoring steps
   function automatic longint point_bearing(input longint x, input longint y);
      longint u, v, z, t, du, dv;
      int     i;
      if (x == 0 && y == 0) return 0;
      u = y;
      v = x;
      z = 0;
      // rear half plane: pre-rotate by a quarter turn
      if (u < 0) begin
         if (v >= 0) begin
            t = u; u = v; v = -t; z = gtp_pkg::QUARTER_TURN;
         end else begin
            t = u; u = -v; v = t; z = -gtp_pkg::QUARTER_TURN;
         end
      end
      u = u * 65536;
      v = v * 65536;
      for (i = 0; i < 16; i++) begin
         du = v >>> i;
         dv = u >>> i;
         if (v >= 0) begin
            u = u + du; v = v - dv; z = z + atan_lut[i];
         end else begin
            u = u - du; v = v + dv; z = z - atan_lut[i];
         end
      end
      return (z + 8) >>> 4;
   endfunction

   // velocity command for one target point under the current registers
   function automatic velocity_cmd_type predict_velocity(input logic signed [15:0] tx,
                                                         input logic signed [15:0] ty);
      velocity_cmd_type cmd;
      longint x, y, range_mm, angle, mag, adv, rmag, rot;
      x        = tx;
      y        = ty;
      range_mm = int_sqrt(x * x + y * y);
      angle    = point_bearing(x, y);
      mag      = (angle < 0) ? -angle : angle;
      adv      = (longint'(shadow_cfg.linear_gain) * range_mm) >> 8;
      rmag     = (longint'(shadow_cfg.angular_gain) * mag) >> 8;
      if (adv > longint'(shadow_cfg.max_forward_speed)) adv = shadow_cfg.max_forward_speed;
      if (mag > longint'(shadow_cfg.turn_only_angle)) adv = 0;
      if (rmag > longint'(shadow_cfg.max_turn_rate)) rmag = shadow_cfg.max_turn_rate;
      rot       = (angle < 0) ? -rmag : rmag;
      cmd.speed = adv[14:0];
      cmd.turn  = rot[15:0];
      return cmd;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic report_error(input string msg);
      error_count++;
      $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // compare each accepted command with the oldest prediction
   always @(posedge clock) begin : check_commands
      velocity_cmd_type exp_cmd;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cmds.size() == 0) begin
            report_error($sformatf("command %h with no point outstanding", rsp_tdata));
         end else begin
            exp_cmd = pending_cmds.pop_front();
            if (rsp_tdata[14:0] !== exp_cmd.speed)
               report_error($sformatf("forward_speed %0d, predicted %0d",
                                      rsp_tdata[14:0], exp_cmd.speed));
            if (rsp_tdata[30:15] !== exp_cmd.turn)
               report_error($sformatf("turn_rate %0d, predicted %0d",
                                      $signed(rsp_tdata[30:15]), exp_cmd.turn));
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // drivers, entered and left at a falling edge
   // ---------------------------------------------------------------------

   // one register write; csr_valid is left high for a following write
   task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         gtp_pkg::REG_MAX_FORWARD_SPEED: shadow_cfg.max_forward_speed = value[14:0];
         gtp_pkg::REG_MAX_TURN_RATE:     shadow_cfg.max_turn_rate     = value[14:0];
         gtp_pkg::REG_LINEAR_GAIN:       shadow_cfg.linear_gain       = value;
         gtp_pkg::REG_ANGULAR_GAIN:      shadow_cfg.angular_gain      = value;
         gtp_pkg::REG_TURN_ONLY_ANGLE:   shadow_cfg.turn_only_angle   = value[13:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] fwd_max, input logic [15:0] turn_max,
                                 input logic [15:0] lin_gain, input logic [15:0] ang_gain,
                                 input logic [15:0] turn_only);
      write_reg(gtp_pkg::REG_MAX_FORWARD_SPEED, fwd_max);
      write_reg(gtp_pkg::REG_MAX_TURN_RATE, turn_max);
      write_reg(gtp_pkg::REG_LINEAR_GAIN, lin_gain);
      write_reg(gtp_pkg::REG_ANGULAR_GAIN, ang_gain);
      write_reg(gtp_pkg::REG_TURN_ONLY_ANGLE, turn_only);
      csr_valid <= 1'b0;
   endtask

   // one target point; req_tvalid stays high for a back-to-back point
   task automatic send_point(input logic signed [15:0] tx, input logic signed [15:0] ty);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ty, tx};
      do @(posedge clock); while (!req_tready);
      pending_cmds.insert(pending_cmds.size(), predict_velocity(tx, ty));
      @(negedge clock);
   endtask

   // stop sending and wait until every command has come back
   task automatic drain_commands();
      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(negedge clock);
   endtask

   // random point: full range, near the robot, mid range or on an axis
   task automatic send_random_point();
      int xi, yi;
      case ($urandom_range(3))
         0: begin
            xi = $urandom_range(65535) - 32768;
            yi = $urandom_range(65535) - 32768;
         end
         1: begin
            xi = $urandom_range(400) - 200;
            yi = $urandom_range(400) - 200;
         end
         2: begin
            xi = $urandom_range(8000) - 4000;
            yi = $urandom_range(8000) - 4000;
         end
         default: begin
            xi = $urandom_range(65535) - 32768;
            case ($urandom_range(4))
               0: yi = 0;
               1: yi = 1;
               2: yi = -1;
               3: yi = -32768;
               default: yi = 32767;
            endcase
            if ($urandom_range(1)) begin
               xi = xi + yi;
               yi = xi - yi;
               xi = xi - yi;
            end
         end
      endcase
      send_point(xi[15:0], yi[15:0]);
   endtask

   // register value: an extreme, near the usual value, or anything
   function automatic logic [15:0] pick_setting(input int typical);
      case ($urandom_range(5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(typical * 4));
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // corner points under the reset settings
   task automatic test_directed_points();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_point(16'sd0, 16'sd0);            // origin
      send_point(16'sd0, -16'sd1);           // straight behind
      send_point(16'sd0, -16'sd32768);
      send_point(16'sd0, 16'sd32767);        // straight ahead, far
      send_point(16'sd32767, 16'sd0);
      send_point(-16'sd32768, 16'sd0);
      send_point(-16'sd32768, -16'sd32768);  // largest distance
      send_point(16'sd32767, 16'sd32767);
      send_point(-16'sd32768, 16'sd32767);
      send_point(16'sd32767, -16'sd32768);
      send_point(16'sd1, -16'sd1);
      send_point(-16'sd1, -16'sd1);
      send_point(-16'sd1, 16'sd0);
      send_point(16'sd1, 16'sd0);
      send_point(-16'sd1, 16'sd1);
      send_point(16'sd100, 16'sd100);
      send_point(16'sd670, 16'sd1500);       // bearing near the turn-only threshold
      send_point(-16'sd670, 16'sd1500);
      send_point(16'sd3, -16'sd32768);       // either side of straight behind
      send_point(-16'sd3, -16'sd32768);
      drain_commands();
   endtask

   // all-zero and all-ones registers, write masking and unused indexes
   task automatic test_register_extremes();
      int n;
      apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      for (n = 0; n < 8; n++) send_random_point();
      drain_commands();
      // bits above each register width are dropped
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (n = 0; n < 8; n++) send_random_point();
      drain_commands();
      apply_settings(16'd32767, 16'd32767, 16'd256, 16'd256, 16'd12868);
      write_reg(REG_UNUSED_FIRST, 16'($urandom_range(65535)));
      write_reg(REG_UNUSED_LAST, 16'($urandom_range(65535)));
      csr_valid <= 1'b0;
      for (n = 0; n < 8; n++) send_random_point();
      drain_commands();
   endtask

   // random points in four bursts, each under fresh register settings
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int count);
      int burst, n;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (burst = 0; burst < 4; burst++) begin
         apply_settings(pick_setting(1000), pick_setting(4096), pick_setting(128),
                        pick_setting(384), pick_setting(1638));
         for (n = 0; n < count / 4; n++) send_random_point();
         drain_commands();
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      shadow_cfg.max_forward_speed = 15'd1000;
      shadow_cfg.max_turn_rate     = 15'd4096;
      shadow_cfg.linear_gain       = 16'd128;
      shadow_cfg.angular_gain      = 16'd384;
      shadow_cfg.turn_only_angle   = 14'd1638;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_points();
      test_register_extremes();
      test_random_traffic(27, 47, RANDOM_POINTS / 3);
      test_random_traffic(47, 27, RANDOM_POINTS / 3);
      test_random_traffic(0, 0, RANDOM_POINTS / 3);

      repeat (PIPE_LATENCY + 10) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> go_to_point_velocity_controller_top.f
sv/gtp_pkg.sv
sv/gtp_front.sv
sv/gtp_cell.sv
sv/gtp_back.sv
sv/go_to_point_velocity_controller_top.sv
tb/tb_go_to_point_velocity_controller_top.sv
